// ===== rtl/core/cps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the class proportion score core.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int PIX_W      = 8;
    localparam int TH_W       = 17;
    localparam int QUOT_W     = 15;
    localparam int MASK_W     = 64;
    localparam int MASK_WORDS = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // 25600 = 2^14 + 2^13 + 2^10 (100 percent in 1/256-percent units)
    localparam logic [QUOT_W-1:0] FULL_SCALE = 15'd25600;
    localparam int FS_SH0 = 14;
    localparam int FS_SH1 = 13;
    localparam int FS_SH2 = 10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MASK_0     = 3'd0,
        CFG_MASK_1     = 3'd1,
        CFG_MASK_2     = 3'd2,
        CFG_MASK_3     = 3'd3,
        CFG_NODATA_VAL = 3'd4,
        CFG_NODATA_EN  = 3'd5,
        CFG_MIN_TH     = 3'd6,
        CFG_MAX_TH     = 3'd7
    } cps_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_COUNT,
        ST_CAPTURE,
        ST_DIV_PROP,
        ST_SCORE,
        ST_DIV_SCORE,
        ST_DONE
    } cps_state_t;

    typedef struct packed {
        logic count;       // accepted pixel word
        logic capture;     // latch totals, clear counters
        logic div_load;    // load divider
        logic div_score;   // divider operands: 1 score, 0 proportion
        logic div_step;    // one quotient bit
        logic score_eval;  // latch proportion, decide score
        logic out_load;    // load result word
    } cps_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic need_div;
        logic div_last;
    } cps_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/cps_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_div
// Restoring divider, one quotient bit per cycle, QUOT_W-bit quotient.
// The caller guarantees the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module cps_div import cps_pkg::*; #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 33
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic              step,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic      [QUOT_W-1:0] quot,
    output logic                   last
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] num_lo_reg, num_lo_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W:0]    trial;
    logic              ge;

    always_comb begin
        trial       = {rem_reg, num_lo_reg[QUOT_W-1]};
        ge          = (trial >= {1'b0, den_reg});
        rem_next    = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        num_lo_next = {num_lo_reg[QUOT_W-2:0], 1'b0};
        quot_next   = {quot_reg[QUOT_W-2:0], ge};
        cnt_next    = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= CNT_W'(QUOT_W - 1);
        end else if (step) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg    <= DEN_W'(num[NUM_W-1:QUOT_W]);
            num_lo_reg <= num[QUOT_W-1:0];
            den_reg    <= den;
            quot_reg   <= '0;
        end else if (step) begin
            rem_reg    <= rem_next;
            num_lo_reg <= num_lo_next;
            quot_reg   <= quot_next;
        end
    end

    assign quot = quot_reg;
    assign last = (cnt_reg == '0);

endmodule
`default_nettype wire

// ===== rtl/core/cps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer: counts pixel words, then runs the proportion and, when needed, the
// score division and hands the result to the output register.
// ----------------------------------------------------------------------------
module cps_ctrl import cps_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire cps_status_t status,
    output cps_cmd_t         cmd
);

    cps_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COUNT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_COUNT: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.count = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_CAPTURE;
                    end
                end
            end
            ST_CAPTURE: begin
                cmd.capture = 1'b1;
                if (status.total_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV_PROP;
                end
            end
            ST_DIV_PROP: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE: begin
                cmd.score_eval = 1'b1;
                if (status.need_div) begin
                    cmd.div_load  = 1'b1;
                    cmd.div_score = 1'b1;
                    state_next    = ST_DIV_SCORE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_SCORE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_COUNT;
                end
            end
            default: begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result word overwritten while pending");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_PROP && $past(state_reg) != ST_DIV_PROP)
        |-> ##QUOT_W (state_reg == ST_SCORE))
        else $error("proportion division length wrong");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COUNT) |-> !cmd.count)
        else $error("pixel counted outside count phase");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/cps_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_dp
// Datapath: configuration registers, saturating counters, shared divider,
// score decision and output register.
// ----------------------------------------------------------------------------
module cps_dp import cps_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [PIX_W-1:0]      pixel_class,
    input  wire cps_cmd_t              cmd,
    output cps_status_t                status,
    output logic      [QUOT_W-1:0]     proportion,
    output logic      [QUOT_W-1:0]     score,
    output logic                       no_valid_pixels
);

    localparam int NUM_W = (COUNT_WIDTH + QUOT_W > 32) ? COUNT_WIDTH + QUOT_W : 32;
    localparam int DEN_W = (COUNT_WIDTH + 1 > TH_W + 1) ? COUNT_WIDTH + 1 : TH_W + 1;

    logic [MASK_WORDS-1:0][MASK_W-1:0] mask_reg;
    logic [PIX_W-1:0]       nodata_val_reg;
    logic                   nodata_en_reg;
    logic [TH_W-1:0]        min_th_reg;
    logic [TH_W-1:0]        max_th_reg;

    logic [COUNT_WIDTH-1:0] sel_cnt_reg;
    logic [COUNT_WIDTH-1:0] oth_cnt_reg;
    logic [COUNT_WIDTH:0]   total;

    logic                   zero_reg;
    logic [QUOT_W-1:0]      prop_reg;
    logic [QUOT_W-1:0]      score_reg;
    logic                   use_div_reg;

    logic [QUOT_W-1:0]      prop_out_reg;
    logic [QUOT_W-1:0]      score_out_reg;
    logic                   nvp_out_reg;

    logic                   skip;
    logic                   hit;
    logic [NUM_W-1:0]       sel_ext;
    logic [NUM_W-1:0]       prop_num;
    logic [NUM_W-1:0]       score_num;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [QUOT_W-1:0]      quot;
    logic                   div_last;

    logic signed [TH_W:0]   p_s;
    logic signed [TH_W:0]   lo_s;
    logic signed [TH_W:0]   hi_s;
    logic signed [TH_W:0]   p_diff;
    logic signed [TH_W:0]   th_range;
    logic [NUM_W-1:0]       diff_ext;
    logic                   th_eq;
    logic                   p_ge_hi;
    logic                   p_le_lo;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg       <= '0;
            nodata_val_reg <= '0;
            nodata_en_reg  <= 1'b1;
            min_th_reg     <= '0;
            max_th_reg     <= TH_W'(FULL_SCALE);
        end else if (cfg_wr_en) begin
            unique case (cps_cfg_idx_t'(cfg_addr))
                CFG_MASK_0:     mask_reg[0]    <= cfg_wdata;
                CFG_MASK_1:     mask_reg[1]    <= cfg_wdata;
                CFG_MASK_2:     mask_reg[2]    <= cfg_wdata;
                CFG_MASK_3:     mask_reg[3]    <= cfg_wdata;
                CFG_NODATA_VAL: nodata_val_reg <= cfg_wdata[PIX_W-1:0];
                CFG_NODATA_EN:  nodata_en_reg  <= cfg_wdata[0];
                CFG_MIN_TH:     min_th_reg     <= cfg_wdata[TH_W-1:0];
                CFG_MAX_TH:     max_th_reg     <= cfg_wdata[TH_W-1:0];
                default:        ;
            endcase
        end
    end

    // pixel classification and counters
    assign skip  = nodata_en_reg && (pixel_class == nodata_val_reg);
    assign hit   = mask_reg[pixel_class[7:6]][pixel_class[5:0]];
    assign total = {1'b0, sel_cnt_reg} + {1'b0, oth_cnt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.capture) begin
            sel_cnt_reg <= '0;
            oth_cnt_reg <= '0;
        end else if (cmd.count && !skip) begin
            // saturate at all ones
            if (hit) begin
                if (sel_cnt_reg != '1) begin
                    sel_cnt_reg <= sel_cnt_reg + COUNT_WIDTH'(1);
                end
            end else begin
                if (oth_cnt_reg != '1) begin
                    oth_cnt_reg <= oth_cnt_reg + COUNT_WIDTH'(1);
                end
            end
        end
    end

    // score thresholds against the proportion held in the divider
    always_comb begin
        p_s      = signed'({{(TH_W + 1 - QUOT_W){1'b0}}, quot});
        lo_s     = signed'({min_th_reg[TH_W-1], min_th_reg});
        hi_s     = signed'({max_th_reg[TH_W-1], max_th_reg});
        p_diff   = p_s - lo_s;
        th_range = hi_s - lo_s;
        th_eq    = (lo_s == hi_s);
        p_ge_hi  = (p_s >= hi_s);
        p_le_lo  = (p_s <= lo_s);
        diff_ext = NUM_W'(p_diff[TH_W-1:0]);
        sel_ext  = NUM_W'(sel_cnt_reg);
    end

    assign prop_num  = (sel_ext << FS_SH0) + (sel_ext << FS_SH1) + (sel_ext << FS_SH2);
    assign score_num = (diff_ext << FS_SH0) + (diff_ext << FS_SH1) + (diff_ext << FS_SH2);
    assign div_num   = cmd.div_score ? score_num : prop_num;
    assign div_den   = cmd.div_score ? DEN_W'(th_range[TH_W-1:0]) : DEN_W'(total);

    cps_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .num     (div_num),
        .den     (div_den),
        .quot    (quot),
        .last    (div_last)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            zero_reg <= (total == '0);
        end
        if (cmd.score_eval) begin
            prop_reg    <= quot;
            use_div_reg <= !th_eq && !p_le_lo && !p_ge_hi;
            if (th_eq) begin
                score_reg <= p_ge_hi ? FULL_SCALE : '0;
            end else if (p_le_lo) begin
                score_reg <= '0;
            end else begin
                score_reg <= FULL_SCALE;
            end
        end
        if (cmd.out_load) begin
            nvp_out_reg <= zero_reg;
            if (zero_reg) begin
                prop_out_reg  <= '0;
                score_out_reg <= '0;
            end else begin
                prop_out_reg  <= prop_reg;
                score_out_reg <= use_div_reg ? quot : score_reg;
            end
        end
    end

    assign status.total_zero = (total == '0);
    assign status.need_div   = !th_eq && !p_le_lo && !p_ge_hi;
    assign status.div_last   = div_last;

    assign proportion      = prop_out_reg;
    assign score           = score_out_reg;
    assign no_valid_pixels = nvp_out_reg;

`ifndef SYNTHESIS
    a_cnt_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (sel_cnt_reg == '0 && oth_cnt_reg == '0))
        else $error("counters not cleared after last pixel");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (prop_out_reg <= FULL_SCALE && score_out_reg <= FULL_SCALE))
        else $error("result word out of range");

    a_nvp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && zero_reg) |=> (prop_out_reg == '0 && score_out_reg == '0))
        else $error("empty raster gave nonzero result");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/class_proportion_score_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// class_proportion_score_core
// Share of selected land-cover classes in a pixel stream, plus a score.
// ----------------------------------------------------------------------------
// Input channel s_*: one pixel class per word, s_tlast on the final pixel.
// Words are taken one per cycle while the block counts. Pixels equal to the
// nodata value (when enabled) are skipped; others count as selected or other
// by the 256-bit class mask. Counters saturate at 2^COUNT_WIDTH - 1.
// After the last pixel the block stops taking words, divides for the
// proportion on a bit-serial divider and, when the proportion lies strictly
// between the thresholds, divides again for the score. m_tvalid rises as the
// result word enters the output register; input reopens in that same cycle.
// A raster with no counted pixel skips both divisions.
// Output channel m_*: one word per raster. A finished word sits in the output
// register; the block keeps counting the next raster while it waits and
// stalls only if a second result is ready before the first is taken.
// The user must write configuration through cfg_* only while idle; the block
// itself does not enforce this. Reset (aresetn low, synchronous) clears counters,
// the pending result and the registers to their defaults: empty mask, nodata 0 enabled, thresholds 0 and 25600.
// ----------------------------------------------------------------------------
module class_proportion_score_core import cps_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] pixel_class
    input  wire logic                  s_tlast,   // last_pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [31:0]           m_tdata,   // [14:0] proportion, [29:15] score
    output logic                       m_tuser    // no_valid_pixels
);

    cps_cmd_t          cmd;
    cps_status_t       status;
    logic [QUOT_W-1:0] proportion;
    logic [QUOT_W-1:0] score;
    logic              no_valid_pixels;

    cps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cps_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .pixel_class     (s_tdata[PIX_W-1:0]),
        .cmd             (cmd),
        .status          (status),
        .proportion      (proportion),
        .score           (score),
        .no_valid_pixels (no_valid_pixels)
    );

    assign m_tdata = {2'b00, score, proportion};
    assign m_tuser = no_valid_pixels;

endmodule
`default_nettype wire

// ===== test/class_proportion_score_core_test.sv =====
// ----------------------------------------------------------------------------
// class_proportion_score_core_test
// Streams rasters of class pixels through the core and checks every result
// word (proportion, score, no-valid flag) against an in-bench prediction.
// Covers default registers, nodata skipping, mask edges, threshold shapes
// (ordered, equal, inverted, full range), random rasters under three idle
// mixes and a long receiver hold-off that fills the core.
// ----------------------------------------------------------------------------
module class_proportion_score_core_test import cps_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W       = 32;
    localparam int SETTLE      = 40;    // longest result latency plus margin
    localparam int HOLD_CYCLES = 400;
    localparam int EXP_DEPTH   = 16;

    typedef struct packed {
        logic [QUOT_W-1:0] proportion;
        logic [QUOT_W-1:0] score;
        logic              no_valid;
    } raster_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tuser;

    // predicted core state
    logic [MASK_W-1:0] class_mask [MASK_WORDS];
    logic [PIX_W-1:0]  nd_val;
    logic              nd_en;
    logic [TH_W-1:0]   min_th;
    logic [TH_W-1:0]   max_th;
    logic [CNT_W-1:0]  sel_cnt;
    logic [CNT_W-1:0]  oth_cnt;

    // expected result words, written by the sender, read by the receiver
    raster_result_t exp_mem [EXP_DEPTH];
    int             exp_wr        = 0;
    int             exp_rd        = 0;
    int             err_count     = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    logic           hold_req      = 1'b0;
    logic           rx_hold       = 1'b0;

    class_proportion_score_core #(.COUNT_WIDTH(CNT_W)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [QUOT_W-1:0] score_for(longint p);
        longint lo;
        longint hi;
        lo = $signed(min_th);
        hi = $signed(max_th);
        if (lo == hi)
            return (p >= hi) ? FULL_SCALE : '0;
        if (p <= lo)
            return '0;
        if (p >= hi)
            return FULL_SCALE;
        return QUOT_W'(((p - lo) * FULL_SCALE) / (hi - lo));
    endfunction

    // Count one pixel; on the last pixel produce the raster result and clear.
    function automatic bit count_pixel(input logic [7:0] pix, input logic last,
                                       output raster_result_t res);
        logic [MASK_W-1:0] word;
        longint unsigned   total;
        longint unsigned   prop;
        res = '0;
        if (!(nd_en && pix == nd_val)) begin
            word = class_mask[pix[7:6]];
            if (word[pix[5:0]]) begin
                if (sel_cnt != '1)
                    sel_cnt = sel_cnt + 1'b1;
            end else if (oth_cnt != '1) begin
                oth_cnt = oth_cnt + 1'b1;
            end
        end
        if (!last)
            return 1'b0;
        total = 64'(sel_cnt) + 64'(oth_cnt);
        if (total == 0) begin
            res.no_valid = 1'b1;
        end else begin
            prop           = (64'(sel_cnt) * FULL_SCALE) / total;
            res.proportion = prop[QUOT_W-1:0];
            res.score      = score_for(longint'(prop));
        end
        sel_cnt = '0;
        oth_cnt = '0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] junk_above(int width, logic [63:0] v);
        logic [63:0] keep;
        keep = (64'd1 << width) - 1;
        return ({$urandom, $urandom} & ~keep) | (v & keep);
    endfunction

    // Receiver: check each result word, then pick next cycle's tready.
    always @(posedge aclk) begin : rx_side
        raster_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_rd == exp_wr) begin
                report_mismatch("unexpected result word", m_tdata, 0);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tdata[14:0] !== want.proportion)
                    report_mismatch("proportion", m_tdata[14:0], want.proportion);
                if (m_tdata[29:15] !== want.score)
                    report_mismatch("score", m_tdata[29:15], want.score);
                if (m_tuser !== want.no_valid)
                    report_mismatch("no_valid_pixels", m_tuser, want.no_valid);
            end
        end
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                rx_hold  <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold  <= 1'b0;
            end
        end
    end

    task automatic send_pixel(logic [7:0] pix, logic last);
        raster_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        if (count_pixel(pix, last, res)) begin
            exp_mem[exp_wr % EXP_DEPTH] = res;
            exp_wr++;
        end
    endtask

    task automatic send_raster(int len, int nodata_pct, output int counted);
        logic [7:0] pix;
        counted = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < nodata_pct)
                pix = nd_val;
            else
                pix = $urandom_range(255);
            if (!(nd_en && pix == nd_val))
                counted++;
            send_pixel(pix, i == len - 1);
        end
    endtask

    // Drop valid, drain results, then let the core settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (exp_rd == exp_wr);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cps_cfg_idx_t idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MASK_0:     class_mask[0] = val;
            CFG_MASK_1:     class_mask[1] = val;
            CFG_MASK_2:     class_mask[2] = val;
            CFG_MASK_3:     class_mask[3] = val;
            CFG_NODATA_VAL: nd_val = val[PIX_W-1:0];
            CFG_NODATA_EN:  nd_en  = val[0];
            CFG_MIN_TH:     min_th = val[TH_W-1:0];
            CFG_MAX_TH:     max_th = val[TH_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_config(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                                logic [63:0] m3, logic [63:0] ndv, logic [63:0] nde,
                                logic [63:0] lo, logic [63:0] hi);
        write_reg(CFG_MASK_0, m0);
        write_reg(CFG_MASK_1, m1);
        write_reg(CFG_MASK_2, m2);
        write_reg(CFG_MASK_3, m3);
        write_reg(CFG_NODATA_VAL, ndv);
        write_reg(CFG_NODATA_EN, nde);
        write_reg(CFG_MIN_TH, lo);
        write_reg(CFG_MAX_TH, hi);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic randomize_setup();
        logic [63:0] m [MASK_WORDS];
        int          a;
        int          b;
        logic [16:0] lo;
        logic [16:0] hi;
        for (int k = 0; k < MASK_WORDS; k++) begin
            case ($urandom_range(7))
                0:       m[k] = '0;
                1:       m[k] = '1;
                default: m[k] = {$urandom, $urandom};
            endcase
        end
        a = $urandom_range(25600);
        b = $urandom_range(25600);
        case ($urandom_range(5))
            0: begin                        // equal thresholds
                lo = 17'(a);
                hi = 17'(a);
            end
            1: begin                        // inverted
                lo = 17'((a > b) ? a : b + 1);
                hi = 17'((a > b) ? b : a);
            end
            2: begin                        // anywhere in the signed range
                lo = 17'($urandom);
                hi = 17'($urandom);
            end
            3: begin                        // range extremes
                lo = 17'h10000;
                hi = 17'h0FFFF;
            end
            default: begin                  // ordered inside 0..25601 (100 percent plus one)
                lo = 17'((a < b) ? a : b);
                hi = 17'((a < b) ? b : a + 1);
            end
        endcase
        apply_config(m[0], m[1], m[2], m[3],
                     junk_above(PIX_W, $urandom_range(255)),
                     junk_above(1, $urandom_range(1)),
                     junk_above(TH_W, 64'(lo)), junk_above(TH_W, 64'(hi)));
    endtask

    task automatic set_default_prediction();
        for (int k = 0; k < MASK_WORDS; k++)
            class_mask[k] = '0;
        nd_val  = '0;
        nd_en   = 1'b1;
        min_th  = '0;
        max_th  = 17'(FULL_SCALE);
        sel_cnt = '0;
        oth_cnt = '0;
    endtask

    // Registers as left by reset: empty mask, class 0 is nodata.
    task automatic test_reset_defaults();
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd5, 1'b1);
        wait_idle();
    endtask

    task automatic test_nodata_and_mask();
        apply_config('1, '1, '1, '1, 64'd255, 64'd1, 64'd0, 64'd25600);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b1);
        wait_idle();
        // only the two outermost classes selected, nodata off
        apply_config(64'd1, '0, '0, 64'h8000_0000_0000_0000, 64'd0, 64'd0,
                     64'd0, 64'd25600);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b1);
        wait_idle();
    endtask

    task automatic test_threshold_shapes();
        // equal thresholds: step at the threshold
        apply_config(64'd1, '0, '0, 64'h8000_0000_0000_0000, 64'd0, 64'd0,
                     64'd12800, 64'd12800);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b1);
        wait_idle();
        // inverted thresholds
        apply_config(64'd1, '0, '0, 64'h8000_0000_0000_0000, 64'd0, 64'd0,
                     64'd20000, 64'd5000);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b1);
        send_pixel(8'd1, 1'b1);
        wait_idle();
        // widest signed range, junk above bit 16
        apply_config(64'd1, '0, '0, 64'h8000_0000_0000_0000, 64'd0, 64'd0,
                     -65536, 64'hABCD_0000_0000_FFFF);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd1, 1'b1);
        wait_idle();
        // both thresholds at full scale
        apply_config(64'd1, '0, '0, 64'h8000_0000_0000_0000, 64'd0, 64'd0,
                     64'd25600, 64'd25600);
        send_pixel(8'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_rasters(int send_pct, int recv_pct, int target);
        int done;
        int blk;
        int got;
        int len;
        int pct;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        done = 0;
        while (done < target) begin
            wait_idle();
            randomize_setup();
            blk = 0;
            while (blk < 50) begin
                len = ($urandom_range(15) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 10);
                if ($urandom_range(9) == 0)
                    pct = 100;
                else
                    pct = ($urandom_range(1) == 0) ? 0 : 15;
                send_raster(len, pct, got);
                blk += got;
            end
            done += blk;
        end
        wait_idle();
    endtask

    // Hold the receiver so the output register fills and input stalls.
    task automatic test_backpressure();
        int got;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req <= 1'b1;
        for (int r = 0; r < 6; r++)
            send_raster(4, 0, got);
        wait_idle();
    endtask

    initial begin
        set_default_prediction();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_nodata_and_mask();
        test_threshold_shapes();
        test_random_rasters(10, 78, 160);
        test_random_rasters(78, 10, 160);
        test_random_rasters(0, 0, 160);
        test_backpressure();
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
